// ----- hdl/fan_tach_capture_registers_core_macros.svh -----
// Assertion macros used by the checker file.
`ifndef FAN_TACH_CAPTURE_REGISTERS_CORE_MACROS_SVH
`define FAN_TACH_CAPTURE_REGISTERS_CORE_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define FTCR_ASSERT_NOW(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("ftcr assertion failed");

// Next-cycle implication, disabled during reset.
`define FTCR_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("ftcr assertion failed");

`endif

// ----- hdl/ftcr_pkg.sv -----
package ftcr_pkg;

  localparam int unsigned DUTY_FULL_SCALE = 1000000;
  localparam int unsigned FAN_COUNT       = 4;

  localparam int unsigned MAXRPM_W = 16;
  localparam int unsigned DUTY_W   = 20;
  localparam int unsigned ICP_W    = 48;
  localparam int unsigned PROD_W   = MAXRPM_W + DUTY_W;
  localparam int unsigned NS_W     = 35;
  localparam int unsigned PERIOD_W = ICP_W + 9;
  localparam int unsigned DIV_W    = 64;
  localparam int unsigned STEP_W   = $clog2(PROD_W + 1);
  localparam int unsigned TICK_FRAC = 16;

  localparam int unsigned NREGS = 15;
  localparam int unsigned CFG_IDX_W = 3;

  localparam logic [63:0] NS_PER_MINUTE = 64'd60000000000;
  localparam logic [63:0] PULSES_PER_REV = 64'd2;
  localparam logic [63:0] NS_PER_PULSE_NUM = NS_PER_MINUTE / PULSES_PER_REV;
  localparam logic [15:0] CNT_TOP = 16'hFFFF;

  // Register indexes
  localparam logic [3:0] R_CNT1   = 4'd0;
  localparam logic [3:0] R_CRA    = 4'd1;
  localparam logic [3:0] R_CRB    = 4'd2;
  localparam logic [3:0] R_CNT2   = 4'd3;
  localparam logic [3:0] R_PRSC   = 4'd4;
  localparam logic [3:0] R_CKC    = 4'd5;
  localparam logic [3:0] R_MCTRL  = 4'd6;
  localparam logic [3:0] R_ICTRL  = 4'd7;
  localparam logic [3:0] R_ICLR   = 4'd8;
  localparam logic [3:0] R_IEN    = 4'd9;
  localparam logic [3:0] R_CPA    = 4'd10;
  localparam logic [3:0] R_CPB    = 4'd11;
  localparam logic [3:0] R_CPCFG  = 4'd12;
  localparam logic [3:0] R_INASEL = 4'd13;
  localparam logic [3:0] R_INBSEL = 4'd14;

  // Config register indexes
  localparam logic [CFG_IDX_W-1:0] C_MAXRPM3 = 3'd3;
  localparam logic [CFG_IDX_W-1:0] C_ICP     = 3'd4;

  typedef enum logic [1:0] {
    MODE_READ  = 2'd0,
    MODE_WRITE = 2'd1,
    MODE_DUTY  = 2'd2,
    MODE_RECAP = 2'd3
  } mode_e;

  typedef struct packed {
    logic [1:0]  mode;
    logic [3:0]  reg_index;
    logic [1:0]  access_bytes;
    logic [15:0] write_data;
    logic [1:0]  fan_index;
    logic [19:0] duty_value;
  } in_t;

  typedef struct packed {
    logic [15:0] read_data;
    logic        access_error;
    logic        irq_out;
  } out_t;

  function automatic logic access_ok(input logic [3:0] idx, input logic [1:0] bytes);
    logic ok;
    if (idx > R_INBSEL) begin
      ok = 1'b0;
    end else if (idx <= R_CNT2 || idx == R_CPA || idx == R_CPB) begin
      ok = (bytes == 2'd2);
    end else begin
      ok = (bytes == 2'd1);
    end
    return ok;
  endfunction

endpackage

// ----- hdl/fan_tach_capture_registers_core.sv -----
// Fan tachometer capture block: fifteen 16-bit registers, two capture channels.
// Input channel (in_valid_i / in_stall_o / in_data_i): one item is a bus read,
// bus write, duty update or recapture request. Output channel (out_valid_o /
// out_stall_i / out_data_o): one result item per input item.
// Config port (cfg_valid_i / cfg_ready_o): max rpm of four fans and the input
// clock period; always ready. The user must see that it is written only while
// the block is idle; the block does not enforce this. Items that run no capture
// go from S_DISP to the result. With MCTRL bit 2 set, each enabled channel can run
// a 36-step rpm division, a 35-step period division and a 16-step tick division
// on one shared restoring divider. One item is in flight at a time; in_stall_o
// is high from acceptance until its result has been taken.
// Reset clears the register file, duties, config and the interrupt level.
// When the receiver stalls, the result is held and no new item is taken.
module fan_tach_capture_registers_core #(
  parameter int unsigned DutyFullScale = ftcr_pkg::DUTY_FULL_SCALE
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  ftcr_pkg::in_t                    in_data_i,
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output ftcr_pkg::out_t                   out_data_o,
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  logic [ftcr_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [ftcr_pkg::ICP_W-1:0]       cfg_data_i
);
  import ftcr_pkg::*;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_DISP  = 3'd1;
  localparam logic [2:0] S_CHSEL = 3'd2;
  localparam logic [2:0] S_LOAD  = 3'd3;
  localparam logic [2:0] S_DIV   = 3'd4;
  localparam logic [2:0] S_POST  = 3'd5;
  localparam logic [2:0] S_APPLY = 3'd6;

  localparam logic [1:0] PH_RPM  = 2'd0;
  localparam logic [1:0] PH_NS   = 2'd1;
  localparam logic [1:0] PH_TICK = 2'd2;

  logic [2:0]  state_q, state_d;
  logic [15:0] regs_q [NREGS];
  logic [15:0] regs_d [NREGS];
  logic [DUTY_W-1:0]   duty_q [FAN_COUNT];
  logic [DUTY_W-1:0]   duty_d [FAN_COUNT];
  logic [MAXRPM_W-1:0] maxrpm_q [FAN_COUNT];
  logic [ICP_W-1:0]    icp_q;
  logic irq_q, irq_d, lvl_q, lvl_d, ch_q, ch_d, cap_q, cap_d;
  logic out_valid_q, out_valid_d;
  logic [1:0] phase_q, phase_d;

  logic [STEP_W-1:0]   cnt_q, cnt_d;
  logic [DIV_W-1:0]    rem_q, rem_d, dvd_q, dvd_d, quo_q, quo_d, div_q, div_d;
  logic [PROD_W-1:0]   prod_q, prod_d;
  logic [PERIOD_W-1:0] period_q, period_d;
  logic [15:0]         tick_q, tick_d;
  logic                under_q, under_d;
  out_t                out_q, out_d;

  logic              in_acc;
  logic              ok;
  logic [15:0]       wdat;
  logic [DIV_W-1:0]  rs, diff;
  logic              ge;
  logic              en;
  logic [1:0]        fan;
  logic [NS_W+TICK_FRAC-1:0] a_val;
  logic [15:0]       tgt, cval, newcnt;
  logic [3:0]        ccfg;
  logic              hit, wr_cnt, wr_cr;
  logic [7:0]        pbit;
  logic              lvl_n;

  assign in_acc      = in_valid_i && !in_stall_o;
  assign in_stall_o  = (state_q != S_IDLE) || out_valid_q;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;
  assign cfg_ready_o = 1'b1;

  // shared restoring-division step
  assign rs   = {rem_q[DIV_W-2:0], dvd_q[DIV_W-1]};
  assign ge   = rs >= div_q;
  assign diff = rs - div_q;

  // channel operands
  assign en   = ch_q ? (regs_q[R_MCTRL][6] && regs_q[R_CKC][3])
                     : (regs_q[R_MCTRL][5] && regs_q[R_CKC][0]);
  assign fan  = {ch_q ? regs_q[R_INBSEL][0] : regs_q[R_INASEL][0], ch_q};
  assign tgt  = ch_q ? regs_q[R_CPB] : regs_q[R_CPA];
  assign ccfg = ch_q ? regs_q[R_CPCFG][7:4] : regs_q[R_CPCFG][3:0];
  assign cval = CNT_TOP - tick_q;
  assign a_val = {quo_q[NS_W-1:0], {TICK_FRAC{1'b0}}};

  // compare / result decode
  always_comb begin
    hit    = 1'b0;
    wr_cnt = 1'b0;
    wr_cr  = 1'b0;
    newcnt = cval;
    pbit   = 8'h04;
    priority if (ccfg[3]) begin
      hit = 1'b1; wr_cnt = 1'b1; newcnt = CNT_TOP;
    end else if (ccfg[2] && (under_q || cval <= tgt)) begin
      hit = 1'b1; wr_cnt = 1'b1; newcnt = tgt;
    end else if (ccfg[1] && tgt != 16'd0 && (under_q || cval < tgt)) begin
      hit = 1'b1; wr_cnt = 1'b1; newcnt = tgt - 16'd1;
    end else if (!under_q) begin
      wr_cnt = 1'b1; wr_cr = 1'b1;
    end
    if (hit) begin
      pbit = 8'h10;
    end else if (wr_cr) begin
      pbit = 8'h01;
    end
    if (ch_q) begin
      pbit = {pbit[6:0], 1'b0};
    end
    lvl_n = lvl_q || ((regs_q[R_IEN][7:0] & pbit) != 8'h00);
  end

  always_comb begin
    state_d     = state_q;
    regs_d      = regs_q;
    duty_d      = duty_q;
    irq_d       = irq_q;
    lvl_d       = lvl_q;
    ch_d        = ch_q;
    cap_d       = cap_q;
    out_valid_d = out_valid_q && out_stall_i;
    phase_d     = phase_q;
    cnt_d       = cnt_q;
    rem_d       = rem_q;
    dvd_d       = dvd_q;
    quo_d       = quo_q;
    div_d       = div_q;
    prod_d      = prod_q;
    period_d    = period_q;
    tick_d      = tick_q;
    under_d     = under_q;
    out_d       = out_q;
    ok          = access_ok(in_data_i.reg_index, in_data_i.access_bytes);
    wdat        = (in_data_i.access_bytes == 2'd1) ? {8'h00, in_data_i.write_data[7:0]}
                                                   : in_data_i.write_data;
    unique case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          out_d.read_data    = 16'h0000;
          out_d.access_error = 1'b0;
          cap_d = 1'b0;
          unique case (mode_e'(in_data_i.mode))
            MODE_READ: begin
              if (!ok) begin
                out_d.access_error = 1'b1;
              end else if (in_data_i.reg_index != R_ICLR) begin
                out_d.read_data = regs_q[in_data_i.reg_index];
              end
            end
            MODE_WRITE: begin
              if (!ok) begin
                out_d.access_error = 1'b1;
              end else if (in_data_i.reg_index == R_ICLR) begin
                regs_d[R_ICTRL] = regs_q[R_ICTRL] & ~{8'h00, wdat[7:0]};
              end else begin
                regs_d[in_data_i.reg_index] = wdat;
                cap_d = 1'b1;
              end
            end
            MODE_DUTY: begin
              duty_d[in_data_i.fan_index] = in_data_i.duty_value;
              cap_d = 1'b1;
            end
            MODE_RECAP: cap_d = 1'b1;
            default: cap_d = 1'b0;
          endcase
          state_d = S_DISP;
        end
      end
      S_DISP: begin
        if (cap_q && regs_q[R_MCTRL][2]) begin
          lvl_d   = 1'b0;
          ch_d    = 1'b0;
          state_d = S_CHSEL;
        end else begin
          out_d.irq_out = irq_q;
          out_valid_d   = 1'b1;
          state_d       = S_IDLE;
        end
      end
      S_CHSEL: begin
        if (en) begin
          prod_d   = maxrpm_q[fan] * duty_q[fan];
          period_d = icp_q * ({1'b0, regs_q[R_PRSC][7:0]} + 9'd1);
          phase_d  = PH_RPM;
          state_d  = S_LOAD;
        end else if (!ch_q) begin
          ch_d = 1'b1;
        end else begin
          irq_d         = lvl_q;
          out_d.irq_out = lvl_q;
          out_valid_d   = 1'b1;
          state_d       = S_IDLE;
        end
      end
      S_LOAD: begin
        rem_d   = '0;
        quo_d   = '0;
        dvd_d   = {prod_q, {(DIV_W-PROD_W){1'b0}}};
        div_d   = DIV_W'(DutyFullScale);
        cnt_d   = STEP_W'(PROD_W);
        state_d = S_DIV;
      end
      S_DIV: begin
        rem_d = ge ? diff : rs;
        quo_d = {quo_q[DIV_W-2:0], ge};
        dvd_d = {dvd_q[DIV_W-2:0], 1'b0};
        cnt_d = cnt_q - STEP_W'(1);
        if (cnt_q == STEP_W'(1)) begin
          state_d = S_POST;
        end
      end
      S_POST: begin
        unique case (phase_q)
          PH_RPM: begin
            if (quo_q == '0) begin
              under_d = 1'b1;
              state_d = S_APPLY;
            end else if (period_q == '0) begin
              under_d = 1'b0;
              tick_d  = 16'h0000;
              state_d = S_APPLY;
            end else begin
              rem_d   = '0;
              quo_d   = '0;
              div_d   = quo_q;
              dvd_d   = {NS_PER_PULSE_NUM[NS_W-1:0], {(DIV_W-NS_W){1'b0}}};
              cnt_d   = STEP_W'(NS_W);
              phase_d = PH_NS;
              state_d = S_DIV;
            end
          end
          PH_NS: begin
            if (PERIOD_W'(a_val) >= period_q) begin
              under_d = 1'b1;
              state_d = S_APPLY;
            end else begin
              rem_d   = DIV_W'(a_val);
              quo_d   = '0;
              dvd_d   = '0;
              div_d   = DIV_W'(period_q);
              cnt_d   = STEP_W'(TICK_FRAC);
              phase_d = PH_TICK;
              state_d = S_DIV;
            end
          end
          PH_TICK: begin
            tick_d  = quo_q[15:0];
            under_d = 1'b0;
            state_d = S_APPLY;
          end
          default: begin
            under_d = 1'b1;
            state_d = S_APPLY;
          end
        endcase
      end
      S_APPLY: begin
        if (wr_cnt) begin
          regs_d[ch_q ? R_CNT2 : R_CNT1] = newcnt;
        end
        if (wr_cr) begin
          regs_d[ch_q ? R_CRB : R_CRA] = newcnt;
        end
        regs_d[R_ICTRL] = regs_q[R_ICTRL] | {8'h00, pbit};
        lvl_d = lvl_n;
        if (!ch_q) begin
          ch_d    = 1'b1;
          state_d = S_CHSEL;
        end else begin
          irq_d         = lvl_n;
          out_d.irq_out = lvl_n;
          out_valid_d   = 1'b1;
          state_d       = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      irq_q       <= 1'b0;
      lvl_q       <= 1'b0;
      ch_q        <= 1'b0;
      cap_q       <= 1'b0;
      out_valid_q <= 1'b0;
      phase_q     <= PH_RPM;
      icp_q       <= '0;
      for (int i = 0; i < NREGS; i++) begin
        regs_q[i] <= 16'h0000;
      end
      for (int i = 0; i < FAN_COUNT; i++) begin
        duty_q[i]   <= '0;
        maxrpm_q[i] <= '0;
      end
    end else begin
      state_q     <= state_d;
      irq_q       <= irq_d;
      lvl_q       <= lvl_d;
      ch_q        <= ch_d;
      cap_q       <= cap_d;
      out_valid_q <= out_valid_d;
      phase_q     <= phase_d;
      regs_q      <= regs_d;
      duty_q      <= duty_d;
      if (cfg_valid_i && cfg_ready_o) begin
        if (cfg_index_i <= C_MAXRPM3) begin
          maxrpm_q[cfg_index_i[1:0]] <= cfg_data_i[MAXRPM_W-1:0];
        end else if (cfg_index_i == C_ICP) begin
          icp_q <= cfg_data_i;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    cnt_q    <= cnt_d;
    rem_q    <= rem_d;
    dvd_q    <= dvd_d;
    quo_q    <= quo_d;
    div_q    <= div_d;
    prod_q   <= prod_d;
    period_q <= period_d;
    tick_q   <= tick_d;
    under_q  <= under_d;
    out_q    <= out_d;
  end

endmodule

// ----- hdl/ftcr_checker.sv -----
`include "fan_tach_capture_registers_core_macros.svh"

module ftcr_checker (
  input logic           clk_i,
  input logic           rst_ni,
  input logic           in_valid_i,
  input logic           in_stall_o,
  input logic           out_valid_o,
  input logic           out_stall_i,
  input ftcr_pkg::out_t out_data_o
);
  import ftcr_pkg::*;

  // a held result is not replaced
  `FTCR_ASSERT_NXT(a_out_hold, clk_i, rst_ni, out_valid_o && out_stall_i, out_valid_o && $stable(out_data_o))
  // one item in flight: busy right after acceptance
  `FTCR_ASSERT_NXT(a_busy_after_acc, clk_i, rst_ni, in_valid_i && !in_stall_o, in_stall_o)
  // no new item while a result waits
  `FTCR_ASSERT_NOW(a_no_acc_pending, clk_i, rst_ni, out_valid_o, in_stall_o)
  // rejected accesses read as zero
  `FTCR_ASSERT_NOW(a_err_zero, clk_i, rst_ni, out_valid_o && out_data_o.access_error, out_data_o.read_data == 16'h0000)

endmodule

bind fan_tach_capture_registers_core ftcr_checker u_ftcr_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_data_o  (out_data_o)
);
